// File: rtl/dq_pkg.sv
// Package for the circular deque: request codes, widths and the control
// group that the top level broadcasts to the row of storage cells.
// No dependencies.
package dq_pkg;

    // Width of one stored entry and of the capacity register.
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;
    localparam int REQ_W  = 3;

    // Capacity register value after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // Request codes carried by req_type.
    typedef enum logic [REQ_W-1:0] {
        REQ_NONE       = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_PUSH_BACK  = 3'd2,
        REQ_POP_FRONT  = 3'd3,
        REQ_POP_BACK   = 3'd4
    } req_t;

    // Shift controls shared by every cell of the row.
    typedef struct packed {
        logic shift_right;   // take the left neighbor's entry (push at front)
        logic shift_left;    // take the right neighbor's entry (pop at front)
    } cell_ctrl_t;

endpackage

// File: rtl/dq_in_if.sv
// Request channel of the circular deque: valid/ready plus one request beat.
// Depends on dq_pkg for the field widths.
interface dq_in_if
    import dq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

// File: rtl/dq_out_if.sv
// Response channel of the circular deque: valid/ready plus one result beat.
// Depends on dq_pkg for the field widths.
interface dq_out_if
    import dq_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;

    modport source (output valid, output ok, output front_value, output rear_value,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input ok, input front_value, input rear_value,
                    input is_empty, input is_full, output ready);
endinterface

// File: rtl/dq_cell.sv
// One storage cell of the deque row. Each cell holds one entry and, on a
// front push or pop, trades it with its neighbor. Depends on dq_pkg.
module dq_cell
    import dq_pkg::*;
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic              load_en,
    input  logic [DATA_W-1:0] load_data,
    input  logic [DATA_W-1:0] from_left,
    input  logic [DATA_W-1:0] from_right,
    output logic [DATA_W-1:0] data,
    output logic [DATA_W-1:0] data_next
);

    logic [DATA_W-1:0] data_reg;

    // Select the entry this cell holds after the current beat.
    always_comb
    begin
        if (ctrl.shift_right)
        begin
            data_next = from_left;
        end
        else if (ctrl.shift_left)
        begin
            data_next = from_right;
        end
        else if (load_en)
        begin
            data_next = load_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    // Entry storage; payload only, so no reset.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: rtl/circular_deque.sv
// Top level of the circular deque: request decode, fill count, capacity
// register, the row of dq_cell storage cells and the response register.
// Depends on dq_pkg, dq_in_if, dq_out_if and dq_cell.
//
//  channel   dir  handshake          beat contents
//  -------   ---  -----------------  --------------------------------------------
//  req_ch    in   valid/ready        req_type, value
//  rsp_ch    out  valid/ready        ok, front_value, rear_value, is_empty, is_full
//  cfg       in   cfg_wr_en only     cfg_wr_data = capacity
//
// Each accepted request is decoded, the cell row shifts or loads, and the
// result is captured in the response register at the same edge.
// The front entry always sits in cell 0 and the rear in cell count-1, so a
// new request can be taken every cycle while the response register is free
// or being emptied. A stalled response holds the request channel off.
// Reset empties the deque and sets capacity to 16; a capacity write also
// empties it. Cell contents are not reset.
module circular_deque
    import dq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data,
    dq_in_if.sink            req_ch,
    dq_out_if.source         rsp_ch
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

    logic [CAP_W-1:0]  capacity_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [CMP_W-1:0]  eff_cap;
    logic [CMP_W-1:0]  cap_ext;
    logic [CMP_W-1:0]  count_ext;
    logic [CMP_W-1:0]  count_next_ext;
    logic              accept;
    logic              ok_next;
    logic              push_back;
    logic              not_full;
    logic              not_empty;
    cell_ctrl_t        ctrl;
    logic [IDX_W-1:0]  rear_idx;
    logic [DEPTH-1:0]  load_sel;
    logic [DATA_W-1:0] cell_data [DEPTH];
    logic [DATA_W-1:0] cell_next [DEPTH];

    logic                     out_valid_reg;
    logic                     ok_reg;
    logic signed [DATA_W-1:0] front_reg;
    logic signed [DATA_W-1:0] rear_reg;
    logic                     empty_reg;
    logic                     full_reg;

    // Effective capacity: zero reads as one, anything above DEPTH as DEPTH.
    assign cap_ext = CMP_W'(capacity_reg);
    always_comb
    begin
        if (capacity_reg == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > DEPTH_C)
        begin
            eff_cap = DEPTH_C;
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign count_ext = CMP_W'(count_reg);
    assign not_full  = (count_ext < eff_cap);
    assign not_empty = (count_reg != '0);

    // Handshake: the response register frees up when its beat is taken.
    assign req_ch.ready = !out_valid_reg || rsp_ch.ready;
    assign accept       = req_ch.valid && req_ch.ready;

    // Request decode into cell controls and the next fill count.
    always_comb
    begin
        ok_next          = 1'b0;
        push_back        = 1'b0;
        ctrl.shift_right = 1'b0;
        ctrl.shift_left  = 1'b0;
        count_next       = count_reg;
        case (req_ch.req_type)
            REQ_NONE:
            begin
                ok_next = 1'b1;
            end
            REQ_PUSH_FRONT:
            begin
                if (not_full)
                begin
                    ok_next          = 1'b1;
                    ctrl.shift_right = accept;
                    count_next       = count_reg + CNT_W'(1);
                end
            end
            REQ_PUSH_BACK:
            begin
                if (not_full)
                begin
                    ok_next    = 1'b1;
                    push_back  = accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            REQ_POP_FRONT:
            begin
                if (not_empty)
                begin
                    ok_next         = 1'b1;
                    ctrl.shift_left = accept;
                    count_next      = count_reg - CNT_W'(1);
                end
            end
            REQ_POP_BACK:
            begin
                if (not_empty)
                begin
                    ok_next    = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    // Row of storage cells; cell 0 is the front of the deque.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_data;
        logic [DATA_W-1:0] right_data;

        assign load_sel[i] = push_back && (count_reg == CNT_W'(i));

        if (i == 0)
        begin : g_first
            assign left_data = req_ch.value;
        end
        else
        begin : g_inner_l
            assign left_data = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_data = cell_data[i];
        end
        else
        begin : g_inner_r
            assign right_data = cell_data[i+1];
        end

        dq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .load_en    (load_sel[i]),
            .load_data  (req_ch.value),
            .from_left  (left_data),
            .from_right (right_data),
            .data       (cell_data[i]),
            .data_next  (cell_next[i])
        );
    end

    // Rear entry after the beat sits just below the new fill count.
    assign count_next_ext = CMP_W'(count_next);
    assign rear_idx       = IDX_W'(count_next - CNT_W'(1));

    // Capacity register and fill count; a capacity write empties the deque.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            count_reg    <= '0;
        end
        else if (cfg_wr_en)
        begin
            capacity_reg <= cfg_wr_data;
            count_reg    <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    // Response register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Response payload, captured with the request that produced it.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg    <= ok_next;
            empty_reg <= (count_next == '0);
            full_reg  <= (count_next_ext == eff_cap);
            if (count_next == '0)
            begin
                front_reg <= '1;
                rear_reg  <= '1;
            end
            else
            begin
                front_reg <= cell_next[0];
                rear_reg  <= cell_next[rear_idx];
            end
        end
    end

    assign rsp_ch.valid       = out_valid_reg;
    assign rsp_ch.ok          = ok_reg;
    assign rsp_ch.front_value = front_reg;
    assign rsp_ch.rear_value  = rear_reg;
    assign rsp_ch.is_empty    = empty_reg;
    assign rsp_ch.is_full     = full_reg;

    // The fill count never exceeds the effective capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_ext <= eff_cap)
        else $error("fill count above capacity");

    // A no-op request always reports success.
    a_noop_ok: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req_ch.req_type == REQ_NONE) |=> rsp_ch.ok)
        else $error("no-op request reported failure");

    // A pop on an empty deque fails and leaves it empty.
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !cfg_wr_en && (count_reg == '0)
        && ((req_ch.req_type == REQ_POP_FRONT) || (req_ch.req_type == REQ_POP_BACK))
        |=> !rsp_ch.ok && rsp_ch.is_empty)
        else $error("pop on empty deque succeeded");

    // Without a capacity write the fill count moves by at most one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cfg_wr_en) && $past(rst_n) |->
        (count_reg == $past(count_reg))
        || (count_reg == $past(count_reg) + CNT_W'(1))
        || (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("fill count jumped");

endmodule

// File: dv/tb_circular_deque.sv
`timescale 1ns / 100ps
// Testbench for circular_deque: directed edge cases, then random request streams
// under several capacities, with random idling on both channels and a shadow deque.
// Depends on dq_pkg, dq_in_if, dq_out_if and the circular_deque RTL.
module tb_circular_deque;
    import dq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_IDLE    = 13;
    localparam int MAX_REPORTS = 10;
    localparam int PHASE_ITEMS = 148;
    localparam logic [REQ_W-1:0]         REQ_CODE_MAX = '1;
    localparam logic signed [DATA_W-1:0] EMPTY_VALUE  = -1;
    localparam logic signed [DATA_W-1:0] VALUE_MAX    = 32'h7fff_ffff;
    localparam logic signed [DATA_W-1:0] VALUE_MIN    = 32'h8000_0000;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] rear_value;
        logic                     is_empty;
        logic                     is_full;
    } deque_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en;
    logic [CAP_W-1:0] cfg_wr_data;

    dq_in_if  req_if ();
    dq_out_if rsp_if ();

    circular_deque #(.DEPTH(DEPTH)) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_ch      (req_if),
        .rsp_ch      (rsp_if)
    );

    // Shadow copy of the deque state and of the capacity register.
    logic [CAP_W-1:0]         shadow_cap;
    logic [PTR_W-1:0]         shadow_head;
    logic [PTR_W-1:0]         shadow_tail;
    logic [CAP_W-1:0]         shadow_count;
    logic signed [DATA_W-1:0] shadow_ring [DEPTH];

    deque_result_t pending_results [$];
    int            mismatch_count = 0;
    int            cycle_count = 0;
    bit            tx_no_idle = 1'b0;
    bit            rx_no_idle = 1'b0;

    // Free-running clock, 20 ns period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Capacity as the block uses it: zero counts as one, above the depth as the depth.
    function automatic logic [CAP_W-1:0] effective_capacity();
        if (shadow_cap == '0)
            return CAP_W'(1);
        if (shadow_cap > DEPTH)
            return CAP_W'(DEPTH);
        return shadow_cap;
    endfunction

    function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p, logic [CAP_W-1:0] cap);
        return (int'(p) + 1 >= int'(cap)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ring_prev(logic [PTR_W-1:0] p, logic [CAP_W-1:0] cap);
        return (p == '0 || int'(p) > int'(cap)) ? PTR_W'(cap - CAP_W'(1)) : p - PTR_W'(1);
    endfunction

    // Apply one request to the shadow deque and return the beat it must produce.
    function automatic deque_result_t predict_deque_result(logic [REQ_W-1:0] req,
                                                           logic signed [DATA_W-1:0] value);
        logic [CAP_W-1:0] cap;
        deque_result_t    r;
        cap  = effective_capacity();
        r.ok = 1'b0;
        case (req)
            REQ_NONE:
                r.ok = 1'b1;
            REQ_PUSH_FRONT:
                if (shadow_count < cap)
                begin
                    shadow_head              = ring_prev(shadow_head, cap);
                    shadow_ring[shadow_head] = value;
                    shadow_count             = shadow_count + CAP_W'(1);
                    r.ok                     = 1'b1;
                end
            REQ_PUSH_BACK:
                if (shadow_count < cap)
                begin
                    shadow_ring[shadow_tail] = value;
                    shadow_tail              = ring_next(shadow_tail, cap);
                    shadow_count             = shadow_count + CAP_W'(1);
                    r.ok                     = 1'b1;
                end
            REQ_POP_FRONT:
                if (shadow_count != '0)
                begin
                    shadow_head  = ring_next(shadow_head, cap);
                    shadow_count = shadow_count - CAP_W'(1);
                    r.ok         = 1'b1;
                end
            REQ_POP_BACK:
                if (shadow_count != '0)
                begin
                    shadow_tail  = ring_prev(shadow_tail, cap);
                    shadow_count = shadow_count - CAP_W'(1);
                    r.ok         = 1'b1;
                end
            default:
                r.ok = 1'b0;
        endcase
        r.is_empty    = (shadow_count == '0);
        r.is_full     = (shadow_count == cap);
        r.front_value = r.is_empty ? EMPTY_VALUE : shadow_ring[shadow_head];
        r.rear_value  = r.is_empty ? EMPTY_VALUE : shadow_ring[ring_prev(shadow_tail, cap)];
        return r;
    endfunction

    task automatic note_mismatch(string what, logic [DATA_W-1:0] exp_v,
                                 logic [DATA_W-1:0] act_v);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, exp_v, act_v);
    endtask

    // Response side: random stalls, with stretches of none.
    initial
    begin : rsp_stall
        int gap;
        rsp_if.ready <= 1'b0;
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rx_no_idle = !rx_no_idle;
            gap = rx_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            if (gap > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_if.valid)
                @(posedge clk);
        end
    end

    // Compare each accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin : rsp_check
        deque_result_t exp_r;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_results.size() == 0)
            begin
                note_mismatch("beat with nothing expected", '0, rsp_if.front_value);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (rsp_if.ok !== exp_r.ok)
                    note_mismatch("ok", DATA_W'(exp_r.ok), DATA_W'(rsp_if.ok));
                if (rsp_if.front_value !== exp_r.front_value)
                    note_mismatch("front_value", exp_r.front_value, rsp_if.front_value);
                if (rsp_if.rear_value !== exp_r.rear_value)
                    note_mismatch("rear_value", exp_r.rear_value, rsp_if.rear_value);
                if (rsp_if.is_empty !== exp_r.is_empty)
                    note_mismatch("is_empty", DATA_W'(exp_r.is_empty),
                                  DATA_W'(rsp_if.is_empty));
                if (rsp_if.is_full !== exp_r.is_full)
                    note_mismatch("is_full", DATA_W'(exp_r.is_full), DATA_W'(rsp_if.is_full));
            end
        end
    end

    // Send one request beat after a random gap; valid stays high when the gap is zero.
    task automatic send_request(logic [REQ_W-1:0] req, logic signed [DATA_W-1:0] value);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_no_idle = !tx_no_idle;
        gap = tx_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid    <= 1'b1;
        req_if.req_type <= req;
        req_if.value    <= value;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        pending_results.push_back(predict_deque_result(req, value));
    endtask

    // Stop sending and wait until every expected beat has come back.
    task automatic drain_requests();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Capacity write; only done with the block idle. It also empties the deque.
    task automatic write_capacity(logic [CAP_W-1:0] cap);
        drain_requests();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        shadow_cap   = cap;
        shadow_head  = '0;
        shadow_tail  = '0;
        shadow_count = '0;
    endtask

    // Pops on an empty deque, no-op and unknown codes, extreme values at both ends.
    task automatic test_directed_edges();
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_POP_BACK, '0);
        send_request(REQ_NONE, VALUE_MAX);
        send_request(REQ_CODE_MAX, '0);
        send_request(REQ_W'(int'(REQ_POP_BACK) + 1), '0);
        send_request(REQ_PUSH_BACK, VALUE_MAX);
        send_request(REQ_PUSH_FRONT, VALUE_MIN);
        send_request(REQ_PUSH_BACK, EMPTY_VALUE);
        send_request(REQ_PUSH_FRONT, '0);
        send_request(REQ_PUSH_BACK, 32'ha5a5_a5a5);
        send_request(REQ_PUSH_FRONT, 32'h5a5a_5a5a);
        send_request(REQ_W'(int'(REQ_POP_BACK) + 2), VALUE_MIN);
        send_request(REQ_POP_BACK, '0);
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_NONE, '0);
    endtask

    // Smallest capacities: one entry, and zero that acts as one.
    task automatic test_capacity_extremes();
        write_capacity(CAP_W'(1));
        send_request(REQ_PUSH_BACK, 32'h1234_5678);
        send_request(REQ_PUSH_FRONT, 32'h8765_4321);
        send_request(REQ_POP_FRONT, '0);
        send_request(REQ_POP_BACK, '0);
        write_capacity('0);
        send_request(REQ_PUSH_FRONT, EMPTY_VALUE);
        send_request(REQ_PUSH_BACK, VALUE_MAX);
        send_request(REQ_POP_BACK, '0);
    endtask

    // Random traffic in phases, each under its own capacity. Pushes and pops come in
    // biased streaks so that the deque keeps running into full and empty.
    task automatic test_random_traffic();
        logic [CAP_W-1:0]         phase_caps [10];
        logic [REQ_W-1:0]         req;
        logic signed [DATA_W-1:0] value;
        bit                       push_heavy;
        int                       pick;
        phase_caps = '{CAP_W'(31), CAP_W'(16), CAP_W'(1), CAP_W'(2), CAP_W'(3),
                       CAP_W'(17), CAP_W'(0), CAP_W'(8), CAP_W'(0), CAP_W'(0)};
        phase_caps[8] = CAP_W'($urandom_range(1, 15));
        phase_caps[9] = CAP_W'($urandom);
        push_heavy = 1'b1;
        foreach (phase_caps[p])
        begin
            write_capacity(phase_caps[p]);
            repeat (PHASE_ITEMS)
            begin
                if ($urandom_range(0, 19) == 0)
                    push_heavy = !push_heavy;
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    req = REQ_W'($urandom_range(int'(REQ_POP_BACK) + 1, int'(REQ_CODE_MAX)));
                else if (pick < 8)
                    req = REQ_NONE;
                else if ($urandom_range(0, 99) < (push_heavy ? 75 : 25))
                    req = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
                else
                    req = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
                case ($urandom_range(0, 15))
                    0:       value = VALUE_MAX;
                    1:       value = VALUE_MIN;
                    2:       value = EMPTY_VALUE;
                    3:       value = '0;
                    default: value = $urandom;
                endcase
                send_request(req, value);
            end
        end
    endtask

    // Test sequence.
    initial
    begin
        req_if.valid    <= 1'b0;
        req_if.req_type <= REQ_NONE;
        req_if.value    <= '0;
        cfg_wr_en       <= 1'b0;
        cfg_wr_data     <= '0;
        shadow_cap   = CAP_RESET;
        shadow_head  = '0;
        shadow_tail  = '0;
        shadow_count = '0;
        foreach (shadow_ring[i])
            shadow_ring[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_edges();
        test_capacity_extremes();
        test_random_traffic();
        drain_requests();

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/dq_pkg.sv
rtl/dq_in_if.sv
rtl/dq_out_if.sv
rtl/dq_cell.sv
rtl/circular_deque.sv
dv/tb_circular_deque.sv
